### design/newton_forward_interpolator_unit_macros.svh
// Assertion macros for the Newton forward interpolator checker.
// Uses clk and rst_n from the including scope; no other dependency.
`ifndef NEWTON_FORWARD_INTERPOLATOR_UNIT_MACROS_SVH
`define NEWTON_FORWARD_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NFI_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define NFI_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/nfi_pkg.sv
// Shared types, sizes and fixed-point helpers of the Newton forward interpolator.
// No dependencies; imported by every module of the block except nfi_ram.
`default_nettype none

package nfi_pkg;

    localparam int MAX_POINTS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DEN_W  = 32 + ADDR_W;          // |h| * (j + 1)
    localparam int NUM_W  = 33 + FRAC_BITS;       // |q - x_j| << FRAC_BITS
    localparam int PM_W   = 64 - FRAC_BITS;       // product >> FRAC_BITS
    localparam int R_W    = DEN_W + 1;            // remainder / product high half
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_ZERO_STEP = 2'd2,
        STAT_SAT       = 2'd3
    } status_t;

    typedef enum logic {
        ALU_DIV = 1'b0,
        ALU_MUL = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD_RA,
        ST_BUILD_RB,
        ST_BUILD_WR,
        ST_EVAL_RD,
        ST_EVAL_LD,
        ST_X_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_WAIT,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] value;
    } sat_val_t;

    // Apply a sign to a magnitude and clamp to the signed 32-bit range.
    function automatic sat_val_t sat_from_mag(input logic [63:0] m, input logic neg);
        sat_val_t r;
        r.sat   = 1'b0;
        r.value = m[31:0];
        if (neg) begin
            if (m > 64'd2147483648) begin
                r.sat   = 1'b1;
                r.value = 32'h8000_0000;
            end
            else begin
                r.value = (~m[31:0]) + 32'd1;
            end
        end
        else if (m > 64'd2147483647) begin
            r.sat   = 1'b1;
            r.value = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // Clamp a 33-bit signed sum or difference to 32 bits.
    function automatic sat_val_t clamp33(input logic [32:0] v);
        sat_val_t r;
        r.sat   = v[32] ^ v[31];
        r.value = v[31:0];
        if (r.sat) begin
            r.value = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // Magnitude of a signed 32-bit value (the most negative value maps to 2^31).
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

### design/newton_forward_interpolator_unit.sv
// Newton forward-difference interpolator: top level with sequencer and node stores.
// Depends on nfi_pkg, nfi_ram and nfi_alu.
//
// Usage
//   s_* channel: one item per accepted beat. s_tuser picks load node, query or clear.
//   Load and clear return nothing and leave s_tready high. A query returns one item
//   on the m_* channel: the interpolated Q15.16 value and a status code.
//   cfg_* channel: writes the node spacing h; always ready, write it only while idle.
//   Query flow: a query with n loaded nodes first turns the f values into the difference
//   table (only on the first query after loading), then evaluates the polynomial.
//   Each of the n*(n-1)/2 ratio/product steps runs through the one shared serial unit:
//   store reads, then a divide, then a multiply.
//   Queries with no nodes, or with a zero step and two or more nodes, skip the table
//   and the polynomial and go straight to the output.
//   s_tready is low while a query is in progress; the serial unit sets the rate.
//   Reset clears the node count, the table flags and the output valid, and sets h to
//   1.0. The node stores themselves are not cleared.
//   A stalled receiver holds the result in the output register; the next item is still
//   accepted, and a following query waits at its end until that register empties.
`default_nettype none

module newton_forward_interpolator_unit
    import nfi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // in: [31:0] node_x, [63:32] node_f, [95:64] query_x
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,
    // in: [1:0] operation
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out: [31:0] interp_value
    output logic      [31:0] m_tdata,
    // out: [1:0] status
    output logic      [1:0]  m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    // Control state
    state_t           state_reg, state_next;
    logic [31:0]      step_h_reg, step_h_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             built_reg, built_next;      // difference table is in place
    logic             tsat_reg, tsat_next;        // table build clamped somewhere
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath
    logic [31:0]      q_reg, q_next;
    logic [31:0]      hi_reg, hi_next;
    logic [31:0]      term_reg, term_next;
    logic [31:0]      acc_reg, acc_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic             esat_reg, esat_next;
    status_t          stat_reg, stat_next;
    logic [31:0]      out_data_reg, out_data_next;
    status_t          out_user_reg, out_user_next;

    // Stores and shared unit
    logic              d_we, x_we;
    logic [ADDR_W-1:0] waddr, d_raddr, x_raddr;
    logic [31:0]       d_wdata, d_rdata, x_rdata;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [NUM_W-1:0]  alu_opa, alu_quot;
    logic [DEN_W-1:0]  alu_opb;
    logic [PM_W-1:0]   alu_prod;

    logic [31:0]       hmag;
    logic [CNT_W-1:0]  base;
    logic [32:0]       diff33;
    logic [32:0]       dmag;
    sat_val_t          sv;
    logic [31:0]       rmag;

    nfi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_diff_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    nfi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (waddr),
        .wdata (s_tdata[31:0]),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    nfi_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .opa   (alu_opa),
        .opb   (alu_opb),
        .rsp   (alu_rsp),
        .quot  (alu_quot),
        .prod  (alu_prod)
    );

    assign hmag      = mag32(step_h_reg);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_h_next    = cfg_valid ? cfg_data : step_h_reg;
        count_next     = count_reg;
        built_next     = built_reg;
        tsat_next      = tsat_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        q_next         = q_reg;
        hi_next        = hi_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        esat_next      = esat_reg;
        stat_next      = stat_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        d_we    = 1'b0;
        x_we    = 1'b0;
        waddr   = i_reg[ADDR_W-1:0];
        d_wdata = s_tdata[63:32];
        d_raddr = i_reg[ADDR_W-1:0];
        x_raddr = j_reg[ADDR_W-1:0];
        alu_req = '{start: 1'b0, op: ALU_DIV};
        alu_opa = '0;
        alu_opb = den_reg;

        base   = built_reg ? '0 : count_reg;
        diff33 = '0;
        dmag   = '0;
        sv     = '0;
        rmag   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        OP_LOAD:
                        begin
                            // A load after a query that reached evaluation starts a fresh node set.
                            built_next = 1'b0;
                            tsat_next  = built_reg ? 1'b0 : tsat_reg;
                            count_next = base;
                            if (base < CNT_W'(MAX_POINTS))
                            begin
                                d_we       = 1'b1;
                                x_we       = 1'b1;
                                waddr      = base[ADDR_W-1:0];
                                count_next = base + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            built_next = 1'b0;
                            tsat_next  = 1'b0;
                        end
                        OP_QUERY:
                        begin
                            q_next = s_tdata[95:64];
                            if (count_reg == '0)
                            begin
                                acc_next   = '0;
                                stat_next  = STAT_EMPTY;
                                state_next = ST_DONE;
                            end
                            else if (count_reg >= CNT_W'(2) && step_h_reg == '0)
                            begin
                                acc_next   = '0;
                                stat_next  = STAT_ZERO_STEP;
                                state_next = ST_DONE;
                            end
                            else if (!built_reg && count_reg >= CNT_W'(2))
                            begin
                                j_next     = CNT_W'(1);
                                i_next     = count_reg - CNT_W'(1);
                                tsat_next  = 1'b0;
                                state_next = ST_BUILD_RA;
                            end
                            else
                            begin
                                built_next = 1'b1;
                                i_next     = '0;
                                acc_next   = '0;
                                esat_next  = 1'b0;
                                state_next = ST_EVAL_RD;
                            end
                        end
                        default:
                        begin
                            // Unused code: drop the item.
                        end
                    endcase
                end
            end

            ST_BUILD_RA:
            begin
                d_raddr    = i_reg[ADDR_W-1:0];
                state_next = ST_BUILD_RB;
            end

            ST_BUILD_RB:
            begin
                hi_next    = d_rdata;
                d_raddr    = i_reg[ADDR_W-1:0] - ADDR_W'(1);
                state_next = ST_BUILD_WR;
            end

            ST_BUILD_WR:
            begin
                diff33  = {hi_reg[31], hi_reg} - {d_rdata[31], d_rdata};
                sv      = clamp33(diff33);
                d_we    = 1'b1;
                waddr   = i_reg[ADDR_W-1:0];
                d_wdata = sv.value;
                if (sv.sat)
                begin
                    tsat_next = 1'b1;
                end
                if (i_reg == j_reg)
                begin
                    if (j_reg + CNT_W'(1) == count_reg)
                    begin
                        built_next = 1'b1;
                        i_next     = '0;
                        acc_next   = '0;
                        esat_next  = 1'b0;
                        state_next = ST_EVAL_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        i_next     = count_reg - CNT_W'(1);
                        state_next = ST_BUILD_RA;
                    end
                end
                else
                begin
                    i_next     = i_reg - CNT_W'(1);
                    state_next = ST_BUILD_RA;
                end
            end

            ST_EVAL_RD:
            begin
                d_raddr    = i_reg[ADDR_W-1:0];
                state_next = ST_EVAL_LD;
            end

            ST_EVAL_LD:
            begin
                term_next  = d_rdata;
                j_next     = '0;
                den_next   = DEN_W'(hmag);
                state_next = (i_reg == '0) ? ST_ACC : ST_X_RD;
            end

            ST_X_RD:
            begin
                x_raddr    = j_reg[ADDR_W-1:0];
                state_next = ST_DIV_GO;
            end

            ST_DIV_GO:
            begin
                // ratio = (|q - x_j| << FRAC_BITS) / (|h| * (j + 1))
                diff33      = {q_reg[31], q_reg} - {x_rdata[31], x_rdata};
                dmag        = diff33[32] ? (33'd0 - diff33) : diff33;
                neg_next    = diff33[32] ^ step_h_reg[31];
                alu_req     = '{start: 1'b1, op: ALU_DIV};
                alu_opa     = {dmag, {FRAC_BITS{1'b0}}};
                alu_opb     = den_reg;
                state_next  = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    sv = sat_from_mag({{(64-NUM_W){1'b0}}, alu_quot}, neg_reg);
                    if (sv.sat)
                    begin
                        esat_next = 1'b1;
                    end
                    rmag       = mag32(sv.value);
                    neg_next   = sv.value[31] ^ term_reg[31];
                    alu_req    = '{start: 1'b1, op: ALU_MUL};
                    alu_opa    = {{(NUM_W-32){1'b0}}, rmag};
                    alu_opb    = {{(DEN_W-32){1'b0}}, mag32(term_reg)};
                    state_next = ST_MUL_WAIT;
                end
            end

            ST_MUL_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    sv = sat_from_mag({{FRAC_BITS{1'b0}}, alu_prod}, neg_reg);
                    if (sv.sat)
                    begin
                        esat_next = 1'b1;
                    end
                    term_next  = sv.value;
                    j_next     = j_reg + CNT_W'(1);
                    den_next   = den_reg + DEN_W'(hmag);
                    state_next = (j_reg + CNT_W'(1) < i_reg) ? ST_X_RD : ST_ACC;
                end
            end

            ST_ACC:
            begin
                sv       = clamp33({acc_reg[31], acc_reg} + {term_reg[31], term_reg});
                acc_next = sv.value;
                if (sv.sat)
                begin
                    esat_next = 1'b1;
                end
                if (i_reg + CNT_W'(1) < count_reg)
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_EVAL_RD;
                end
                else
                begin
                    stat_next  = (esat_reg || sv.sat || tsat_reg) ? STAT_SAT : STAT_OK;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    out_user_next  = stat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_h_reg    <= 32'd65536;
            count_reg     <= '0;
            built_reg     <= 1'b0;
            tsat_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_h_reg    <= step_h_next;
            count_reg     <= count_next;
            built_reg     <= built_next;
            tsat_reg      <= tsat_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        hi_reg       <= hi_next;
        term_reg     <= term_next;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        esat_reg     <= esat_next;
        stat_reg     <= stat_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

`default_nettype wire

### design/nfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/nfi_alu.sv
// Shared bit-serial unit: restoring divide and shift-add multiply on one adder.
// Depends on nfi_pkg.
`default_nettype none

module nfi_alu
    import nfi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire alu_req_t         req,
    input  wire logic [NUM_W-1:0] opa,   // dividend, or multiplier in low 32 bits
    input  wire logic [DEN_W-1:0] opb,   // divisor, or multiplicand in low 32 bits
    output alu_rsp_t              rsp,
    output logic      [NUM_W-1:0] quot,
    output logic      [PM_W-1:0]  prod
);

    alu_op_t           op_reg, op_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [R_W-1:0]    r_reg, r_next;
    logic [NUM_W-1:0]  w_reg, w_next;
    logic [DEN_W-1:0]  a_reg, a_next;

    logic [R_W-1:0]    add_x, add_y;
    logic              add_cin;
    logic [R_W:0]      add_sum;

    // One adder: trial subtract for divide, partial-product add for multiply.
    always_comb
    begin
        if (op_reg == ALU_DIV)
        begin
            add_x   = {r_reg[DEN_W-1:0], w_reg[NUM_W-1]};
            add_y   = ~{1'b0, a_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = r_reg;
            add_y   = w_reg[0] ? {{(R_W-32){1'b0}}, a_reg[31:0]} : '0;
            add_cin = 1'b0;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {{R_W{1'b0}}, add_cin};
    end

    always_comb
    begin
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        r_next    = r_reg;
        w_next    = w_reg;
        a_next    = a_reg;
        if (req.start)
        begin
            op_next  = req.op;
            r_next   = '0;
            w_next   = opa;
            a_next   = opb;
            cnt_next = (req.op == ALU_DIV) ? STEP_W'(NUM_W) : STEP_W'(32);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
            if (op_reg == ALU_DIV)
            begin
                r_next = add_sum[R_W] ? add_sum[R_W-1:0] : add_x;
                w_next = {w_reg[NUM_W-2:0], add_sum[R_W]};
            end
            else
            begin
                r_next = add_sum[R_W:1];
                w_next = {w_reg[NUM_W-1:32], add_sum[0], w_reg[31:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= ALU_DIV;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        w_reg <= w_next;
        a_reg <= a_next;
    end

    assign rsp.done = done_reg;
    assign quot     = w_reg;
    assign prod     = {r_reg[31:0], w_reg[31:FRAC_BITS]};

endmodule

`default_nettype wire

### design/nfi_checker.sv
// Port-level checker for the Newton forward interpolator, bound to the top level.
// Depends on nfi_pkg and newton_forward_interpolator_unit_macros.svh.
`default_nettype none

`include "newton_forward_interpolator_unit_macros.svh"

module nfi_checker
    import nfi_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result holds.
    `NFI_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Error statuses carry a zero value.
    `NFI_IMPLIES(a_err_zero, m_tvalid && (m_tuser == STAT_EMPTY || m_tuser == STAT_ZERO_STEP), m_tdata == 32'd0, "error status with nonzero value")

    // A query occupies the block.
    `NFI_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser == OP_QUERY, !s_tready, "ready right after a query")

    // Load and clear do not stall the input.
    `NFI_NEXT(a_load_fast, s_tvalid && s_tready && (s_tuser == OP_LOAD || s_tuser == OP_CLEAR), s_tready, "load or clear stalled input")

endmodule

bind newton_forward_interpolator_unit nfi_checker u_nfi_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench of the Newton forward-difference interpolator unit.
// Depends on nfi_pkg and newton_forward_interpolator_unit; drives loads, queries and clears.
`timescale 1ns / 100ps

module testbench;
    import nfi_pkg::*;

    localparam int FB        = 16;
    localparam int CAP       = 16;
    localparam longint QMAXV = 64'sd2147483647;
    localparam longint QMINV = -64'sd2147483648;
    localparam int LIMIT_CYC = 4_000_000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] nx;
        logic [31:0] nf;
        logic [31:0] qx;
    } item_t;

    typedef struct packed {
        logic [31:0] val;
        logic [1:0]  stat;
    } result_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    newton_forward_interpolator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block state
    logic signed [31:0] xs [CAP];
    logic signed [31:0] ds [CAP];
    int                 npts;
    bit                 built;
    bit                 built_sat;
    logic signed [31:0] h_step;

    result_t pending_results [$];
    int      errors;
    int      cycles;

    function automatic logic signed [31:0] clamp64(longint v, ref bit sat);
        if (v > QMAXV) begin
            sat = 1;
            return 32'h7FFF_FFFF;
        end
        if (v < QMINV) begin
            sat = 1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] apply_sign(logic [63:0] m, bit neg, ref bit sat);
        if (neg) begin
            if (m > 64'd2147483648) begin
                sat = 1;
                return 32'h8000_0000;
            end
            return -m[31:0];
        end
        if (m > 64'd2147483647) begin
            sat = 1;
            return 32'h7FFF_FFFF;
        end
        return m[31:0];
    endfunction

    function automatic logic [63:0] magof(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Advance the mirrored state by one item; return 1 when a result is due.
    function automatic bit interpolate(item_t it, output result_t r);
        bit                 sat;
        longint             acc;
        longint             dif;
        logic signed [31:0] term;
        logic signed [31:0] ratio;
        logic [63:0]        den;
        logic [63:0]        rm;
        logic [63:0]        pm;
        sat = 0;
        r   = '0;
        case (it.op)
            OP_LOAD:
            begin
                if (built) begin
                    npts      = 0;
                    built     = 0;
                    built_sat = 0;
                end
                if (npts < CAP) begin
                    xs[npts] = it.nx;
                    ds[npts] = it.nf;
                    npts++;
                end
                return 0;
            end
            OP_CLEAR:
            begin
                npts      = 0;
                built     = 0;
                built_sat = 0;
                return 0;
            end
            OP_QUERY: ;
            default: return 0;
        endcase
        if (npts == 0) begin
            r.stat = STAT_EMPTY;
            return 1;
        end
        if (npts >= 2 && h_step == 0) begin
            r.stat = STAT_ZERO_STEP;
            return 1;
        end
        if (!built) begin
            // turn f values into the top row of the difference table in place
            for (int j = 1; j < npts; j++)
                for (int i = npts - 1; i >= j; i--)
                    ds[i] = clamp64(longint'(ds[i]) - longint'(ds[i - 1]), built_sat);
            built = 1;
        end
        acc = 0;
        for (int i = 0; i < npts; i++) begin
            term = ds[i];
            for (int j = 0; j < i; j++) begin
                dif   = longint'($signed(it.qx)) - longint'(xs[j]);
                den   = magof(longint'(h_step)) * (j + 1);
                rm    = (magof(dif) << FB) / den;
                ratio = apply_sign(rm, (dif < 0) != (h_step < 0), sat);
                pm    = (magof(longint'(term)) * magof(longint'(ratio))) >> FB;
                term  = apply_sign(pm, (term < 0) != (ratio < 0), sat);
            end
            acc = clamp64(acc + longint'(term), sat);
        end
        r.val  = acc[31:0];
        r.stat = (sat || built_sat) ? STAT_SAT : STAT_OK;
        return 1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Timeout watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYC) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: stall pattern of its own, check each accepted result
    initial begin
        result_t want;
        int      phase;
        m_tready = 0;
        phase    = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 32'd0);
                end
                else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.val)
                        report_mismatch("interp_value", m_tdata, want.val);
                    if (m_tuser !== want.stat)
                        report_mismatch("status", {30'd0, m_tuser}, {30'd0, want.stat});
                end
            end
            @(negedge clk);
            phase = (phase + 1) % 64;
            // steady stretch first, then random stalls
            m_tready <= (phase < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_step(logic [31:0] v);
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
        h_step = v;
    endtask

    // Send one item, updating the mirror at acceptance; hold valid if more follow.
    task automatic send_item(item_t it, bit typed, result_t tr);
        result_t r;
        s_tvalid <= 1;
        s_tuser  <= it.op;
        s_tdata  <= {it.qx, it.nf, it.nx};
        do @(posedge clk); while (!s_tready);
        if (interpolate(it, r)) begin
            if (typed && r.val !== tr.val)
                report_mismatch("typed row value", r.val, tr.val);
            if (typed && r.stat !== tr.stat)
                report_mismatch("typed row status", {30'd0, r.stat}, {30'd0, tr.stat});
            pending_results.push_back(typed ? tr : r);
        end
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        while (pending_results.size() != 0) @(posedge clk);
        // a load or clear may still be in flight
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic item_t mk(logic [1:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        item_t it;
        it.op = op;
        it.nx = a;
        it.nf = b;
        it.qx = c;
        return it;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 20 << FB)) - (10 << FB);
        endcase
    endfunction

    row_t directed [$];

    initial begin
        item_t   it;
        result_t none;
        int      n_pts;
        int      burst;
        int      sent;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = OP_LOAD;
        cfg_valid = 0;
        cfg_data  = '0;
        errors    = 0;
        npts      = 0;
        built     = 0;
        built_sat = 0;
        h_step    = 32'sd65536;
        none      = '0;
        rst_n     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed table: typed rows have their expected result written out
        directed.push_back('{mk(OP_QUERY, 0, 0, 0), 1, '{32'd0, STAT_EMPTY}});
        directed.push_back('{mk(2'd3, 0, 0, 0), 0, none});
        directed.push_back('{mk(OP_LOAD, 32'h7FFF_FFFF, 32'h0003_0000, 0), 0, none});
        directed.push_back('{mk(OP_QUERY, 0, 0, 32'h1234_5678), 1, '{32'h0003_0000, STAT_OK}});
        directed.push_back('{mk(OP_CLEAR, 0, 0, 0), 0, none});
        directed.push_back('{mk(OP_LOAD, 0, 32'h7FFF_FFFF, 0), 0, none});
        directed.push_back('{mk(OP_LOAD, 32'h0001_0000, 32'h8000_0000, 0), 0, none});
        directed.push_back('{mk(OP_QUERY, 0, 0, 0), 1, '{32'h7FFF_FFFF, STAT_SAT}});
        directed.push_back('{mk(OP_QUERY, 0, 0, 32'h8000_0000), 0, none});
        directed.push_back('{mk(OP_LOAD, 0, 32'h0001_0000, 0), 0, none});
        directed.push_back('{mk(OP_LOAD, 32'h0001_0000, 32'h0004_0000, 0), 0, none});
        directed.push_back('{mk(OP_LOAD, 32'h0002_0000, 32'h0009_0000, 0), 0, none});
        directed.push_back('{mk(OP_QUERY, 0, 0, 32'h0001_8000), 0, none});
        directed.push_back('{mk(OP_QUERY, 0, 0, 32'h7FFF_FFFF), 0, none});
        directed.push_back('{mk(OP_CLEAR, 0, 0, 0), 0, none});
        foreach (directed[k])
            send_item(directed[k].it, directed[k].typed, directed[k].res);
        // load past capacity: the last two loads are dropped
        for (int k = 0; k < CAP + 2; k++)
            send_item(mk(OP_LOAD, k << FB, $urandom_range(0, 255) << 12, 0), 0, none);
        send_item(mk(OP_QUERY, 0, 0, 32'h0002_4000), 0, none);
        drain();

        // zero step with a full node set, and with one node
        write_step(32'd0);
        send_item(mk(OP_QUERY, 0, 0, 0), 1, '{32'd0, STAT_ZERO_STEP});
        send_item(mk(OP_CLEAR, 0, 0, 0), 0, none);
        send_item(mk(OP_LOAD, 0, 32'hFFFF_0000, 0), 0, none);
        send_item(mk(OP_QUERY, 0, 0, 32'h0005_0000), 1, '{32'hFFFF_0000, STAT_OK});
        drain();

        // random phases across step settings, extremes among them
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_step(32'h7FFF_FFFF);
                1: write_step(32'h8000_0000);
                2: write_step(32'hFFFF_0000);
                3: write_step(32'h0000_8000);
                4: write_step(32'h0000_0001);
                default: write_step(32'h0001_0000);
            endcase
            while (sent < (ph + 1) * 18) begin
                // mostly well-formed sets of nodes followed by queries
                if ($urandom_range(0, 9) < 8) begin
                    n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(9, CAP) :
                            $urandom_range(1, 6);
                    if ($urandom_range(0, 1)) begin
                        send_item(mk(OP_CLEAR, 0, 0, 0), 0, none);
                        sent++;
                    end
                    for (int k = 0; k < n_pts; k++) begin
                        it = mk(OP_LOAD,
                                (k * h_step) + $urandom_range(0, 3) *
                                ($urandom_range(0, 1) ? $urandom : 0),
                                rnd_word(), 0);
                        send_item(it, 0, none);
                        sent++;
                    end
                    burst = $urandom_range(1, 3);
                    for (int k = 0; k < burst; k++) begin
                        send_item(mk(OP_QUERY, $urandom, $urandom, rnd_word()), 0, none);
                        sent++;
                    end
                end
                else begin
                    send_item(mk($urandom_range(0, 3), rnd_word(), rnd_word(), rnd_word()),
                              0, none);
                    sent++;
                end
                // gap between bursts
                if ($urandom_range(0, 2) == 0) begin
                    s_tvalid <= 0;
                    repeat ($urandom_range(1, 12)) @(negedge clk);
                end
            end
            drain();
        end

        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
